// ----- rtl/mhpf_pkg.sv -----
// shared types, constants and helper functions of the muon hit pattern finder
package mhpf_pkg;

    localparam int unsigned MASK_W  = 28;
    localparam int unsigned HALF_W  = 14;
    localparam int unsigned LVL_W   = 3;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned QUAL_W  = 2;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [LVL_W-1:0]  AGE_MAX = 3'd7;
    localparam logic [LVL_W-1:0]  QUAL_CAP = 3'd3;

    localparam logic [MASK_W-1:0] RST_COLLISION_MASK = 28'hFFF_FFFF;
    localparam logic [LVL_W-1:0]  RST_DRIFT_DELAY    = 3'd0;
    localparam logic [LVL_W-1:0]  RST_PRETRIG_LEVEL  = 3'd2;
    localparam logic [LVL_W-1:0]  RST_TRIG_LEVEL     = 3'd4;

    typedef enum logic [MODE_W-1:0] {
        MODE_NORMAL     = 2'd0,
        MODE_KILL_COLL  = 2'd1,
        MODE_KILL_ACCEL = 2'd2,
        MODE_ACCEL_VETO = 2'd3
    } t_trig_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLLISION_MASK = 3'd0,
        CFG_DRIFT_DELAY    = 3'd1,
        CFG_PRETRIG_LEVEL  = 3'd2,
        CFG_TRIG_LEVEL     = 3'd3,
        CFG_TRIG_MODE      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [MASK_W-1:0] collision_mask;
        logic [LVL_W-1:0]  drift_delay;
        logic [LVL_W-1:0]  pretrigger_level;
        logic [LVL_W-1:0]  trigger_level;
        t_trig_mode        trigger_mode;
    } t_cfg;

    typedef struct packed {
        logic [LVL_W-1:0] accel_count;
        logic [LVL_W-1:0] count_a;
        logic [LVL_W-1:0] count_b;
    } t_counts;

    // number of layers with any hit in a masked 14-bit word
    function automatic logic [LVL_W-1:0] layers_hit(input logic [HALF_W-1:0] m);
        logic [LVL_W-1:0] n;
        n = {2'b00, |m[2:0]} + {2'b00, |m[4:3]} + {2'b00, m[5]}
          + {2'b00, |m[7:6]} + {2'b00, |m[10:8]} + {2'b00, |m[13:11]};
        return n;
    endfunction

    function automatic logic [LVL_W-1:0] bits_set6(input logic [5:0] v);
        logic [LVL_W-1:0] n;
        n = {2'b00, v[0]} + {2'b00, v[1]} + {2'b00, v[2]}
          + {2'b00, v[3]} + {2'b00, v[4]} + {2'b00, v[5]};
        return n;
    endfunction

    function automatic logic [QUAL_W-1:0] cap_qual(input logic [LVL_W-1:0] v);
        logic [QUAL_W-1:0] q;
        q = (v > QUAL_CAP) ? QUAL_CAP[QUAL_W-1:0] : v[QUAL_W-1:0];
        return q;
    endfunction

    function automatic logic [LVL_W-1:0] age_next(
        input logic [LVL_W-1:0] count,
        input logic [LVL_W-1:0] age,
        input logic [LVL_W-1:0] pretrig,
        input logic             kill
    );
        logic [LVL_W-1:0] a;
        if (count < pretrig || kill) begin
            a = '0;
        end else if (age == AGE_MAX) begin
            a = AGE_MAX;
        end else begin
            a = age + 3'd1;
        end
        return a;
    endfunction

endpackage

// ----- rtl/muon_hit_pattern_finder_core.sv -----
// top level of the muon hit pattern finder: config registers, handshake and pipeline
//
// channel   direction  handshake            payload
// hits      in         i_valid / o_ready    i_layer0_hits .. i_layer5_hits
// quality   out        o_valid / i_ready    o_collision_quality, o_accelerator_quality,
//                                           o_pattern_b_chosen
// config    in         i_cfg_wr_en          i_cfg_idx, i_cfg_wdata
//
// one request accepted per cycle while the output is not stalled; its result is valid the cycle after acceptance
// every accepted request moves the whole pipeline one step, so the result of a
// request reflects hits from up to five requests earlier
// a stalled output holds the pipeline; o_ready follows i_ready when a result waits
// synchronous active-low reset restores config defaults and clears the pipeline
module muon_hit_pattern_finder_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [mhpf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mhpf_pkg::MASK_W-1:0]       i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [2:0]                        i_layer0_hits,
    input  logic [1:0]                        i_layer1_hits,
    input  logic                              i_layer2_hit,
    input  logic [1:0]                        i_layer3_hits,
    input  logic [2:0]                        i_layer4_hits,
    input  logic [2:0]                        i_layer5_hits,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [mhpf_pkg::QUAL_W-1:0]       o_collision_quality,
    output logic [mhpf_pkg::QUAL_W-1:0]       o_accelerator_quality,
    output logic                              o_pattern_b_chosen
);

    mhpf_pkg::t_cfg    r_cfg;
    mhpf_pkg::t_counts w_counts;
    logic              r_out_vld;
    logic              w_adv;

    assign o_ready = !r_out_vld || i_ready;
    assign w_adv   = i_valid && o_ready;
    assign o_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.collision_mask   <= mhpf_pkg::RST_COLLISION_MASK;
            r_cfg.drift_delay      <= mhpf_pkg::RST_DRIFT_DELAY;
            r_cfg.pretrigger_level <= mhpf_pkg::RST_PRETRIG_LEVEL;
            r_cfg.trigger_level    <= mhpf_pkg::RST_TRIG_LEVEL;
            r_cfg.trigger_mode     <= mhpf_pkg::MODE_NORMAL;
        end else if (i_cfg_wr_en) begin
            case (mhpf_pkg::t_cfg_idx'(i_cfg_idx))
                mhpf_pkg::CFG_COLLISION_MASK: begin
                    r_cfg.collision_mask <= i_cfg_wdata;
                end
                mhpf_pkg::CFG_DRIFT_DELAY: begin
                    r_cfg.drift_delay <= i_cfg_wdata[mhpf_pkg::LVL_W-1:0];
                end
                mhpf_pkg::CFG_PRETRIG_LEVEL: begin
                    r_cfg.pretrigger_level <= i_cfg_wdata[mhpf_pkg::LVL_W-1:0];
                end
                mhpf_pkg::CFG_TRIG_LEVEL: begin
                    r_cfg.trigger_level <= i_cfg_wdata[mhpf_pkg::LVL_W-1:0];
                end
                mhpf_pkg::CFG_TRIG_MODE: begin
                    r_cfg.trigger_mode <=
                        mhpf_pkg::t_trig_mode'(i_cfg_wdata[mhpf_pkg::MODE_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    mhpf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_cfg         (r_cfg),
        .i_layer0_hits (i_layer0_hits),
        .i_layer1_hits (i_layer1_hits),
        .i_layer2_hit  (i_layer2_hit),
        .i_layer3_hits (i_layer3_hits),
        .i_layer4_hits (i_layer4_hits),
        .i_layer5_hits (i_layer5_hits),
        .o_counts      (w_counts)
    );

    mhpf_score u_score (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_adv                 (w_adv),
        .i_cfg                 (r_cfg),
        .i_counts              (w_counts),
        .o_collision_quality   (o_collision_quality),
        .o_accelerator_quality (o_accelerator_quality),
        .o_pattern_b_chosen    (o_pattern_b_chosen)
    );

endmodule

// ----- rtl/mhpf_front.sv -----
// front stages: hit masking, accelerator bit pick and layer counting
module mhpf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  mhpf_pkg::t_cfg                i_cfg,
    input  logic [2:0]                    i_layer0_hits,
    input  logic [1:0]                    i_layer1_hits,
    input  logic                          i_layer2_hit,
    input  logic [1:0]                    i_layer3_hits,
    input  logic [2:0]                    i_layer4_hits,
    input  logic [2:0]                    i_layer5_hits,
    output mhpf_pkg::t_counts             o_counts
);

    logic [mhpf_pkg::HALF_W-1:0] w_all;
    logic [5:0]                  r_accel_bits, n_accel_bits;
    logic [mhpf_pkg::HALF_W-1:0] r_masked_a, n_masked_a;
    logic [mhpf_pkg::HALF_W-1:0] r_masked_b, n_masked_b;
    mhpf_pkg::t_counts           r_counts, n_counts;

    assign w_all = {i_layer5_hits, i_layer4_hits, i_layer3_hits,
                    i_layer2_hit, i_layer1_hits, i_layer0_hits};

    always_comb begin
        n_accel_bits = {i_layer5_hits[0], i_layer4_hits[0], i_layer3_hits[0],
                        i_layer2_hit, i_layer1_hits[1], i_layer0_hits[2]};
        n_masked_a = w_all & i_cfg.collision_mask[mhpf_pkg::HALF_W-1:0];
        n_masked_b = w_all & i_cfg.collision_mask[mhpf_pkg::MASK_W-1:mhpf_pkg::HALF_W];
        n_counts.accel_count = mhpf_pkg::bits_set6(r_accel_bits);
        n_counts.count_a     = mhpf_pkg::layers_hit(r_masked_a);
        n_counts.count_b     = mhpf_pkg::layers_hit(r_masked_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_bits <= '0;
            r_masked_a   <= '0;
            r_masked_b   <= '0;
            r_counts     <= '0;
        end else if (i_adv) begin
            r_accel_bits <= n_accel_bits;
            r_masked_a   <= n_masked_a;
            r_masked_b   <= n_masked_b;
            r_counts     <= n_counts;
        end
    end

    assign o_counts = r_counts;

endmodule

// ----- rtl/mhpf_score.sv -----
// back stages: drift age counters, scoring, best pattern pick and quality registers
module mhpf_score (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  mhpf_pkg::t_cfg                i_cfg,
    input  mhpf_pkg::t_counts             i_counts,
    output logic [mhpf_pkg::QUAL_W-1:0]   o_collision_quality,
    output logic [mhpf_pkg::QUAL_W-1:0]   o_accelerator_quality,
    output logic                          o_pattern_b_chosen
);

    logic [mhpf_pkg::LVL_W-1:0]  r_accel_age, n_accel_age;
    logic [mhpf_pkg::LVL_W-1:0]  r_age_a, n_age_a;
    logic [mhpf_pkg::LVL_W-1:0]  r_age_b, n_age_b;
    logic [mhpf_pkg::LVL_W-1:0]  r_accel_excess, n_accel_excess;
    logic [mhpf_pkg::LVL_W-1:0]  r_score_a, n_score_a;
    logic [mhpf_pkg::LVL_W-1:0]  r_score_b, n_score_b;
    logic [mhpf_pkg::LVL_W-1:0]  r_best_score, n_best_score;
    logic [mhpf_pkg::LVL_W-1:0]  r_best_excess, n_best_excess;
    logic                        r_best_is_b, n_best_is_b;
    logic [mhpf_pkg::QUAL_W-1:0] r_q_coll, n_q_coll;
    logic [mhpf_pkg::QUAL_W-1:0] r_q_accel, n_q_accel;
    logic                        r_q_flag, n_q_flag;
    logic                        w_kill_coll, w_kill_accel;

    always_comb begin
        w_kill_coll  = (i_cfg.trigger_mode == mhpf_pkg::MODE_KILL_COLL);
        w_kill_accel = (i_cfg.trigger_mode == mhpf_pkg::MODE_KILL_ACCEL);

        if (r_accel_age == i_cfg.drift_delay && i_counts.accel_count >= i_cfg.trigger_level) begin
            n_accel_excess = i_counts.accel_count - i_cfg.trigger_level;
        end else begin
            n_accel_excess = '0;
        end
        n_q_accel = mhpf_pkg::cap_qual(r_accel_excess);

        n_score_a = (r_age_a == i_cfg.drift_delay) ? i_counts.count_a : '0;
        n_score_b = (r_age_b == i_cfg.drift_delay) ? i_counts.count_b : '0;

        // ties go to pattern a
        if (r_score_a >= r_score_b) begin
            n_best_score = r_score_a;
            n_best_is_b  = 1'b0;
        end else begin
            n_best_score = r_score_b;
            n_best_is_b  = 1'b1;
        end

        n_best_excess = (r_best_score >= i_cfg.trigger_level)
                      ? r_best_score - i_cfg.trigger_level : '0;

        if (i_cfg.trigger_mode == mhpf_pkg::MODE_ACCEL_VETO && r_q_accel != '0) begin
            n_q_coll = '0;
        end else begin
            n_q_coll = mhpf_pkg::cap_qual(r_best_excess);
        end
        n_q_flag = r_best_is_b;

        n_age_a = mhpf_pkg::age_next(i_counts.count_a, r_age_a,
                                     i_cfg.pretrigger_level, w_kill_coll);
        n_age_b = mhpf_pkg::age_next(i_counts.count_b, r_age_b,
                                     i_cfg.pretrigger_level, w_kill_coll);
        n_accel_age = mhpf_pkg::age_next(i_counts.accel_count, r_accel_age,
                                         i_cfg.pretrigger_level, w_kill_accel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_age    <= '0;
            r_age_a        <= '0;
            r_age_b        <= '0;
            r_accel_excess <= '0;
            r_score_a      <= '0;
            r_score_b      <= '0;
            r_best_score   <= '0;
            r_best_excess  <= '0;
            r_best_is_b    <= 1'b0;
            r_q_coll       <= '0;
            r_q_accel      <= '0;
            r_q_flag       <= 1'b0;
        end else if (i_adv) begin
            r_accel_age    <= n_accel_age;
            r_age_a        <= n_age_a;
            r_age_b        <= n_age_b;
            r_accel_excess <= n_accel_excess;
            r_score_a      <= n_score_a;
            r_score_b      <= n_score_b;
            r_best_score   <= n_best_score;
            r_best_excess  <= n_best_excess;
            r_best_is_b    <= n_best_is_b;
            r_q_coll       <= n_q_coll;
            r_q_accel      <= n_q_accel;
            r_q_flag       <= n_q_flag;
        end
    end

    assign o_collision_quality   = r_q_coll;
    assign o_accelerator_quality = r_q_accel;
    assign o_pattern_b_chosen    = r_q_flag;

endmodule

// ----- rtl/mhpf_chk.sv -----
// port-level checker for the muon hit pattern finder and its bind
module mhpf_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [mhpf_pkg::QUAL_W-1:0]     o_collision_quality,
    input logic [mhpf_pkg::QUAL_W-1:0]     o_accelerator_quality,
    input logic                            o_pattern_b_chosen
);

    // no result right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_collision_quality)
            && $stable(o_accelerator_quality) && $stable(o_pattern_b_chosen))
        else $error("stalled result changed");

    // input side free whenever the output slot is free or drains
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("request refused with free output slot");

    // every accepted request gives a result
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> o_valid)
        else $error("accepted request produced no result");

    // no invented results
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_valid && o_ready) && (!o_valid || i_ready) |=> !o_valid)
        else $error("result without request");

endmodule

bind muon_hit_pattern_finder_core mhpf_chk u_mhpf_chk (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_valid               (i_valid),
    .o_ready               (o_ready),
    .o_valid               (o_valid),
    .i_ready               (i_ready),
    .o_collision_quality   (o_collision_quality),
    .o_accelerator_quality (o_accelerator_quality),
    .o_pattern_b_chosen    (o_pattern_b_chosen)
);
